// ===== src/whitespace_comment_skipper_unit_assert.svh =====
// ----------------------------------------------------------------------------
// whitespace comment skipper assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n low as disable
// ----------------------------------------------------------------------------
`ifndef WHITESPACE_COMMENT_SKIPPER_UNIT_ASSERT_SVH
`define WHITESPACE_COMMENT_SKIPPER_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define WCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define WCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wcs_pkg.sv =====
// ----------------------------------------------------------------------------
// wcs_pkg
// types, codes and helpers shared by the whitespace comment skipper modules
// ----------------------------------------------------------------------------
`default_nettype none

package wcs_pkg;

  localparam int CNT_W      = 17;
  localparam int COUNT_CAP  = 65536;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DATA_W = 40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_EN  = 2'd2;

  // character codes
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;

  typedef enum logic [2:0] {
    MODE_WS         = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4,
    MODE_BS         = 3'd5,
    MODE_BS_CR      = 3'd6,
    MODE_DONE       = 3'd7
  } scan_mode_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic is_space;
    logic is_lf;
    logic is_cr;
    logic is_slash;
    logic is_star;
    logic is_bsl;
    logic last;
    logic line_en;
    logic block_en;
    logic cont_en;
  } wcs_item_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b,
                                               input logic [CNT_W-1:0] lim);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, lim}) return lim;
    return sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/wcs_front.sv =====
// ----------------------------------------------------------------------------
// wcs_front
// holds the enable registers and classifies each incoming byte
// ----------------------------------------------------------------------------
`default_nettype none

module wcs_front
  import wcs_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire [BYTE_W-1:0]      source_byte,
  input  wire                   last_byte,
  output wcs_item_t             item
);

  logic line_en_r;
  logic block_en_r;
  logic cont_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_en_r  <= 1'b1;
      block_en_r <= 1'b1;
      cont_en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_EN:  line_en_r  <= cfg_wdata[0];
        REG_BLOCK_EN: block_en_r <= cfg_wdata[0];
        REG_CONT_EN:  cont_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.is_space = (source_byte == CH_SPACE) || (source_byte == CH_TAB) ||
                    (source_byte == CH_CR)    || (source_byte == CH_LF)  ||
                    (source_byte == CH_VT)    || (source_byte == CH_FF);
    item.is_lf    = (source_byte == CH_LF);
    item.is_cr    = (source_byte == CH_CR);
    item.is_slash = (source_byte == CH_SLASH);
    item.is_star  = (source_byte == CH_STAR);
    item.is_bsl   = (source_byte == CH_BSL);
    item.last     = last_byte;
    item.line_en  = line_en_r;
    item.block_en = block_en_r;
    item.cont_en  = cont_en_r;
  end

endmodule

`default_nettype wire

// ===== src/wcs_queue.sv =====
// ----------------------------------------------------------------------------
// wcs_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module wcs_queue
  import wcs_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  wire wcs_item_t  push_item,
  output logic            pop_valid,
  input  wire             pop_ready,
  output wcs_item_t       pop_item
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  wcs_item_t           mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [CntW-1:0]     cnt_r;
  logic                push;
  logic                pop;

  assign push_ready = (cnt_r != CntW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `include "whitespace_comment_skipper_unit_assert.svh"

  `WCS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CntW'(QUEUE_DEPTH), "queue count over depth")
  `WCS_ASSERT_NEXT(a_pop_drains, pop && !push && (cnt_r == CntW'(1)), !pop_valid, "queue not empty after last pop")

endmodule

`default_nettype wire

// ===== src/wcs_back.sv =====
// ----------------------------------------------------------------------------
// wcs_back
// scan state machine, skip and newline counters, result register
// ----------------------------------------------------------------------------
`default_nettype none

module wcs_back
  import wcs_pkg::*;
#(
  parameter int BUFFER_BYTES = 65536
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               item_valid,
  output logic              item_ready,
  input  wire wcs_item_t    item,
  output logic              res_valid,
  input  wire               res_ready,
  output logic [CNT_W-1:0]  res_skip,
  output logic [CNT_W-1:0]  res_lines
);

  localparam int LimitInt = (BUFFER_BYTES < COUNT_CAP) ? BUFFER_BYTES : COUNT_CAP;
  localparam logic [CNT_W-1:0] CntLimit = CNT_W'(LimitInt);
  localparam logic [CNT_W-1:0] One      = CNT_W'(1);
  localparam logic [CNT_W-1:0] Two      = CNT_W'(2);

  scan_mode_t        mode_r, mode_nxt;
  logic [CNT_W-1:0]  tent_skip_r, tent_skip_nxt;
  logic [CNT_W-1:0]  tent_lines_r, tent_lines_nxt;
  logic [CNT_W-1:0]  comm_skip_r, comm_skip_nxt;
  logic [CNT_W-1:0]  comm_lines_r, comm_lines_nxt;
  logic [CNT_W-1:0]  comm_skip_upd, comm_lines_upd;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_skip_r;
  logic [CNT_W-1:0]  out_lines_r;
  logic              pop;
  logic              do_commit;
  logic              commit_lf;

  // a last item needs the result slot free or draining
  assign item_ready = !item.last || !out_valid_r || res_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    mode_nxt       = mode_r;
    tent_skip_nxt  = tent_skip_r;
    tent_lines_nxt = tent_lines_r;
    do_commit      = 1'b0;
    commit_lf      = 1'b0;
    unique case (mode_r)
      MODE_WS: begin
        if (item.is_space) begin
          do_commit = 1'b1;
          commit_lf = item.is_lf;
        end else if (item.is_slash && !item.last) begin
          tent_skip_nxt  = One;
          tent_lines_nxt = '0;
          mode_nxt       = MODE_SLASH;
        end else if (item.is_bsl && !item.last && item.cont_en) begin
          tent_skip_nxt  = One;
          tent_lines_nxt = '0;
          mode_nxt       = MODE_BS;
        end else begin
          mode_nxt = MODE_DONE;
        end
      end
      MODE_SLASH: begin
        if (item.is_slash && item.line_en) begin
          do_commit = 1'b1;
          mode_nxt  = MODE_LINE;
        end else if (item.is_star && item.block_en) begin
          tent_skip_nxt  = Two;
          tent_lines_nxt = '0;
          mode_nxt       = MODE_BLOCK;
        end else begin
          mode_nxt = MODE_DONE;
        end
      end
      MODE_LINE: begin
        do_commit = 1'b1;
        commit_lf = item.is_lf;
        if (item.is_lf) mode_nxt = MODE_WS;
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if ((mode_r == MODE_BLOCK_STAR) && item.is_slash) begin
          do_commit = 1'b1;
          mode_nxt  = MODE_WS;
        end else begin
          tent_skip_nxt = sat_add(tent_skip_r, One, CntLimit);
          if (item.is_lf) tent_lines_nxt = sat_add(tent_lines_r, One, CntLimit);
          mode_nxt = item.is_star ? MODE_BLOCK_STAR : MODE_BLOCK;
        end
      end
      MODE_BS: begin
        if (item.is_lf) begin
          do_commit = 1'b1;
          commit_lf = 1'b1;
          mode_nxt  = MODE_WS;
        end else if (item.is_cr && !item.last) begin
          tent_skip_nxt = Two;
          mode_nxt      = MODE_BS_CR;
        end else begin
          mode_nxt = MODE_DONE;
        end
      end
      MODE_BS_CR: begin
        if (item.is_lf) begin
          do_commit = 1'b1;
          commit_lf = 1'b1;
          mode_nxt  = MODE_WS;
        end else begin
          mode_nxt = MODE_DONE;
        end
      end
      MODE_DONE: ;
    endcase

    comm_skip_upd  = comm_skip_r;
    comm_lines_upd = comm_lines_r;
    if (do_commit) begin
      comm_skip_upd  = sat_add(comm_skip_r, sat_add(tent_skip_r, One, CntLimit), CntLimit);
      comm_lines_upd = sat_add(comm_lines_r,
                               sat_add(tent_lines_r, CNT_W'(commit_lf), CntLimit), CntLimit);
      tent_skip_nxt  = '0;
      tent_lines_nxt = '0;
    end
    comm_skip_nxt  = comm_skip_upd;
    comm_lines_nxt = comm_lines_upd;

    // last byte rearms for the next buffer
    if (item.last) begin
      mode_nxt       = MODE_WS;
      tent_skip_nxt  = '0;
      tent_lines_nxt = '0;
      comm_skip_nxt  = '0;
      comm_lines_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_WS;
      tent_skip_r  <= '0;
      tent_lines_r <= '0;
      comm_skip_r  <= '0;
      comm_lines_r <= '0;
    end else if (pop) begin
      mode_r       <= mode_nxt;
      tent_skip_r  <= tent_skip_nxt;
      tent_lines_r <= tent_lines_nxt;
      comm_skip_r  <= comm_skip_nxt;
      comm_lines_r <= comm_lines_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && item.last) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      out_skip_r  <= comm_skip_upd;
      out_lines_r <= comm_lines_upd;
    end
  end

  assign res_valid = out_valid_r;
  assign res_skip  = out_skip_r;
  assign res_lines = out_lines_r;

  `include "whitespace_comment_skipper_unit_assert.svh"

  `WCS_ASSERT_ALWAYS(a_skip_cap, (comm_skip_r <= CntLimit) && (tent_skip_r <= CntLimit), "skip count over limit")
  `WCS_ASSERT_ALWAYS(a_lines_le_skip, (comm_lines_r <= comm_skip_r) && (tent_lines_r <= tent_skip_r), "newlines exceed skipped bytes")
  `WCS_ASSERT_NEXT(a_rearm, pop && item.last, (mode_r == MODE_WS) && (comm_skip_r == '0) && (tent_skip_r == '0) && res_valid, "scan not rearmed after last byte")

endmodule

`default_nettype wire

// ===== src/whitespace_comment_skipper_unit.sv =====
// ----------------------------------------------------------------------------
// whitespace_comment_skipper_unit
// measures leading whitespace, comments and line continuations of a byte stream
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in_      input      in_tvalid/in_tready    tdata[7:0] source_byte, tlast last_byte
// out_     output     out_tvalid/out_tready  tdata[16:0] skipped_bytes,
//                                            tdata[33:17] newline_count
// cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// one byte per cycle sustained while the queue has room; a byte is registered in the queue and
// is applied to the scan state registers when the back end pops it from the queue head
// one result per buffer, out_tvalid is registered and rises once the back end pops its last byte
// reset (synchronous, rst_n low) sets all enables to 1 and clears the scan
// a stalled result holds the next last byte at the queue head; bytes ahead
// of it keep flowing and input stalls once the two-entry queue fills behind it
// ----------------------------------------------------------------------------
`default_nettype none

module whitespace_comment_skipper_unit
  import wcs_pkg::*;
#(
  parameter int BUFFER_BYTES = 65536
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [BYTE_W-1:0]      in_tdata,   // [7:0] source_byte
  input  wire                   in_tlast,   // last_byte
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [16:0] skipped_bytes, [33:17] newline_count
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

  wcs_item_t         front_item;
  wcs_item_t         q_item;
  logic              q_valid;
  logic              q_ready;
  logic [CNT_W-1:0]  res_skip;
  logic [CNT_W-1:0]  res_lines;

  wcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .source_byte (in_tdata),
    .last_byte   (in_tlast),
    .item        (front_item)
  );

  wcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  wcs_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_skip   (res_skip),
    .res_lines  (res_lines)
  );

  assign out_tdata = {{(OUT_DATA_W - 2 * CNT_W){1'b0}}, res_lines, res_skip};

endmodule

`default_nettype wire

// ===== bench/tb_whitespace_comment_skipper_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_whitespace_comment_skipper_unit
// Drives source buffers through the skipper one byte per item and predicts
// the skipped-byte and newline counts that each buffer's last byte returns.
// Covers directed corner cases, all enable settings, long skip runs,
// random buffers with idle gaps and back-pressure, and a back-to-back tail.
// ----------------------------------------------------------------------------

module tb_whitespace_comment_skipper_unit;
  import wcs_pkg::*;

  localparam int BUFFER_BYTES   = 65536;
  localparam int COUNT_LIMIT    = (BUFFER_BYTES < COUNT_CAP) ? BUFFER_BYTES : COUNT_CAP;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_BYTES   = 800;
  localparam int TAIL_BYTES     = 200;
  localparam int LONG_RUN       = 120;
  localparam logic [BYTE_W-1:0] SIG_BYTE = 8'h61;

  typedef struct packed {
    logic [CNT_W-1:0] skip;
    logic [CNT_W-1:0] lines;
  } scan_counts_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  whitespace_comment_skipper_unit #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  scan_mode_t       pred_mode;
  logic [CNT_W-1:0] pend_skip, pend_lines, kept_skip, kept_lines;
  logic             line_on, block_on, cont_on;

  scan_counts_t      counts_due[$];
  logic [BYTE_W-1:0] frame_q[$];

  bit idle_on, stall_on;
  int errors, bytes_sent, frames_sent, results_seen, idle_cycles;

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic logic [CNT_W-1:0] cap_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s >= COUNT_LIMIT) ? CNT_W'(COUNT_LIMIT) : CNT_W'(s);
  endfunction

  function automatic bit is_ws(input logic [BYTE_W-1:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF ||
           b == CH_VT || b == CH_FF;
  endfunction

  function automatic void clear_scan();
    pred_mode  = MODE_WS;
    pend_skip  = '0;
    pend_lines = '0;
    kept_skip  = '0;
    kept_lines = '0;
  endfunction

  // fold the pending run plus the current byte into the kept counts
  function automatic void take_pending(input int extra_bytes, input int extra_lines);
    kept_skip  = cap_add(kept_skip, cap_add(pend_skip, CNT_W'(extra_bytes)));
    kept_lines = cap_add(kept_lines, cap_add(pend_lines, CNT_W'(extra_lines)));
    pend_skip  = '0;
    pend_lines = '0;
  endfunction

  function automatic void apply_byte(input logic [BYTE_W-1:0] b, input logic last);
    scan_counts_t res;
    case (pred_mode)
      MODE_WS: begin
        if (is_ws(b)) begin
          take_pending(1, (b == CH_LF) ? 1 : 0);
        end else if (b == CH_SLASH && !last) begin
          pend_skip  = CNT_W'(1);
          pend_lines = '0;
          pred_mode  = MODE_SLASH;
        end else if (b == CH_BSL && !last && cont_on) begin
          pend_skip  = CNT_W'(1);
          pend_lines = '0;
          pred_mode  = MODE_BS;
        end else begin
          pred_mode = MODE_DONE;
        end
      end
      MODE_SLASH: begin
        if (b == CH_SLASH && line_on) begin
          take_pending(1, 0);
          pred_mode = MODE_LINE;
        end else if (b == CH_STAR && block_on) begin
          pend_skip  = CNT_W'(2);
          pend_lines = '0;
          pred_mode  = MODE_BLOCK;
        end else begin
          pred_mode = MODE_DONE;
        end
      end
      MODE_LINE: begin
        if (b == CH_LF) begin
          take_pending(1, 1);
          pred_mode = MODE_WS;
        end else begin
          take_pending(1, 0);
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (pred_mode == MODE_BLOCK_STAR && b == CH_SLASH) begin
          take_pending(1, 0);
          pred_mode = MODE_WS;
        end else begin
          pend_skip = cap_add(pend_skip, CNT_W'(1));
          if (b == CH_LF) pend_lines = cap_add(pend_lines, CNT_W'(1));
          pred_mode = (b == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
        end
      end
      MODE_BS: begin
        if (b == CH_LF) begin
          take_pending(1, 1);
          pred_mode = MODE_WS;
        end else if (b == CH_CR && !last) begin
          pend_skip = CNT_W'(2);
          pred_mode = MODE_BS_CR;
        end else begin
          pred_mode = MODE_DONE;
        end
      end
      MODE_BS_CR: begin
        if (b == CH_LF) begin
          take_pending(1, 1);
          pred_mode = MODE_WS;
        end else begin
          pred_mode = MODE_DONE;
        end
      end
      default: ;
    endcase
    if (last) begin
      res.skip  = kept_skip;
      res.lines = kept_lines;
      counts_due.push_back(res);
      clear_scan();
    end
  endfunction

  function automatic logic [BYTE_W-1:0] ws_byte();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      3:       return CH_LF;
      4:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 13))
      0, 1, 2: return ws_byte();
      3:       return CH_LF;
      4, 5:    return CH_SLASH;
      6, 7:    return CH_STAR;
      8:       return CH_BSL;
      9:       return CH_CR;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed leading material with random content, some pure noise
  task automatic build_random_frame();
    frame_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(pick_byte());
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, 4)) frame_q.push_back(ws_byte());
        1: begin
          frame_q.push_back(CH_SLASH);
          frame_q.push_back(CH_SLASH);
          repeat ($urandom_range(0, 5)) frame_q.push_back(pick_byte());
          if ($urandom_range(0, 4) != 0) frame_q.push_back(CH_LF);
        end
        2: begin
          frame_q.push_back(CH_SLASH);
          frame_q.push_back(CH_STAR);
          repeat ($urandom_range(0, 6)) frame_q.push_back(pick_byte());
          if ($urandom_range(0, 5) != 0) begin
            frame_q.push_back(CH_STAR);
            frame_q.push_back(CH_SLASH);
          end
        end
        default: begin
          frame_q.push_back(CH_BSL);
          case ($urandom_range(0, 3))
            0, 1: frame_q.push_back(CH_LF);
            2: begin
              frame_q.push_back(CH_CR);
              frame_q.push_back(CH_LF);
            end
            default: begin
              frame_q.push_back(CH_CR);
              frame_q.push_back(pick_byte());
            end
          endcase
        end
      endcase
    end
    repeat ($urandom_range(0, 3)) frame_q.push_back(pick_byte());
    if (frame_q.size() == 0) frame_q.push_back(pick_byte());
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // wait until every result is back and the pipeline has emptied
  task automatic settle();
    in_tvalid <= 1'b0;
    while (counts_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_enables(input logic line_v, input logic block_v, input logic cont_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_EN;
    cfg_wdata <= line_v;
    @(negedge clk);
    cfg_index <= REG_BLOCK_EN;
    cfg_wdata <= block_v;
    @(negedge clk);
    cfg_index <= REG_CONT_EN;
    cfg_wdata <= cont_v;
    @(negedge clk);
    cfg_we  <= 1'b0;
    line_on  = line_v;
    block_on = block_v;
    cont_on  = cont_v;
  endtask

  task automatic test_directed_cases();
    // every whitespace kind, then a slash that is the last byte
    frame_q = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_VT, CH_FF, CH_SLASH};
    send_frame();
    // double slash ending the buffer, line comment with no newline
    frame_q = '{CH_SLASH, CH_SLASH};
    send_frame();
    // star-star-slash closes the comment
    frame_q = '{CH_SLASH, CH_STAR, CH_STAR, CH_STAR, CH_SLASH, SIG_BYTE};
    send_frame();
    // unclosed block comment rolls back to its slash
    frame_q = '{CH_SLASH, CH_STAR, CH_LF, 8'h00};
    send_frame();
    // lone backslash, then backslash with cr as last byte
    frame_q = '{CH_BSL};
    send_frame();
    frame_q = '{CH_BSL, CH_CR};
    send_frame();
    frame_q = '{CH_BSL, CH_CR, CH_LF, CH_BSL, CH_LF, 8'hFF};
    send_frame();
    settle();
  endtask

  task automatic test_enable_sweep();
    for (int s = 0; s < 8; s++) begin
      settle();
      write_enables(s[0], s[1], s[2]);
      repeat (8) begin
        build_random_frame();
        send_frame();
      end
    end
    settle();
  endtask

  task automatic test_long_runs();
    idle_on = 1'b0;
    write_enables(1'b1, 1'b1, 1'b1);
    frame_q.delete();
    repeat (LONG_RUN) frame_q.push_back(CH_LF);
    frame_q.push_back(SIG_BYTE);
    send_frame();
    // the pending run inside a long block comment grows as well
    frame_q = '{CH_SLASH, CH_STAR};
    repeat (LONG_RUN) frame_q.push_back(CH_LF);
    frame_q.push_back(CH_STAR);
    frame_q.push_back(CH_SLASH);
    frame_q.push_back(SIG_BYTE);
    send_frame();
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int goal;
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      if (frames_sent % 6 == 0) begin
        settle();
        write_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
      build_random_frame();
      send_frame();
    end
    settle();
  endtask

  task automatic test_back_to_back();
    int goal;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    write_enables(1'b1, 1'b1, 1'b1);
    goal = bytes_sent + TAIL_BYTES;
    while (bytes_sent < goal) begin
      build_random_frame();
      send_frame();
    end
    settle();
  endtask

  // result checker
  always @(posedge clk) begin
    scan_counts_t due;
    logic [CNT_W-1:0] got_skip, got_lines;
    if (rst_n && out_tvalid && out_tready) begin
      got_skip  = out_tdata[CNT_W-1:0];
      got_lines = out_tdata[2*CNT_W-1:CNT_W];
      results_seen++;
      if (counts_due.size() == 0) begin
        note_error($sformatf("unexpected result: skipped %0d lines %0d",
                             got_skip, got_lines));
      end else begin
        due = counts_due.pop_front();
        if (got_skip !== due.skip || got_lines !== due.lines)
          note_error($sformatf("mismatch: expected skipped %0d lines %0d, got %0d %0d",
                               due.skip, due.lines, got_skip, got_lines));
      end
    end
  end

  // result side back-pressure
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("whitespace_comment_skipper_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_LINE_EN;
    cfg_wdata = '0;
    idle_cycles = 0;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    line_on  = 1'b1;
    block_on = 1'b1;
    cont_on  = 1'b1;
    clear_scan();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_enable_sweep();
    test_long_runs();
    test_random_frames();
    test_back_to_back();

    if (counts_due.size() != 0)
      note_error($sformatf("%0d results never arrived", counts_due.size()));
    $display("ran %0d buffers, %0d bytes, %0d results checked", frames_sent, bytes_sent,
             results_seen);
    $display("all enable settings, long skip runs, idle gaps and stalls covered");
    if (errors == 0) begin
      $display("whitespace_comment_skipper_unit test passed");
    end else begin
      $display("whitespace_comment_skipper_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/wcs_pkg.sv
src/wcs_front.sv
src/wcs_queue.sv
src/wcs_back.sv
src/whitespace_comment_skipper_unit.sv
bench/tb_whitespace_comment_skipper_unit.sv
